// ===== rtl/bitmap_slab_allocator_top_macros.svh =====
// Assertion macros for the slab allocator.
`ifndef BITMAP_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLAB_ALLOCATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BSA_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/bsa_pkg.sv =====
// Package with types, constants and helpers of the slab allocator.
`default_nettype none
package bsa_pkg;
  localparam int NumClasses = 9;
  localparam int MaxPages = 8;
  localparam int PageBytes = 4096;
  localparam int MinObjBytes = 8;
  localparam int SlotsMax = MaxPages * (PageBytes / MinObjBytes);
  localparam int BitmapWords = (SlotsMax + 63) / 64;
  localparam int PageShift = $clog2(PageBytes);
  localparam int MinShift = $clog2(MinObjBytes);
  localparam int ClsW = 4;
  localparam int CidxW = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int PgW = $clog2(MaxPages + 1);
  localparam int PidxW = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int WordW = (BitmapWords > 1) ? $clog2(BitmapWords) : 1;
  localparam int SlotW = $clog2(SlotsMax);
  localparam int CntW = $clog2(SlotsMax + 1);
  localparam int BmDepth = NumClasses * BitmapWords;
  localparam int BmAddrW = $clog2(BmDepth);
  localparam int FrDepth = NumClasses * MaxPages;
  localparam int FrAddrW = $clog2(FrDepth);
  localparam int UsableClasses = (PageShift - MinShift + 1 < NumClasses) ?
                                 PageShift - MinShift + 1 : NumClasses;

  typedef enum logic [2:0] {
    StOk = 3'd0, StPageLimit = 3'd1, StNoSpare = 3'd2, StTooBig = 3'd3,
    StUnknown = 3'd4, StAlreadyFree = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SGrow, SScanRd, SScanChk, SAllocAddr, SFreeRd, SFreeChk, SFreeBmRd,
    SFreeBmChk, SDone
  } fsm_e;

  typedef struct packed {
    logic        action;
    logic [11:0] object_size;
    logic [31:0] free_address;
    logic [19:0] spare_page;
  } in_word_t;

  typedef struct packed {
    logic [31:0] object_address;
    logic [2:0]  status;
    logic        page_taken;
    logic [3:0]  size_class;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic [BmAddrW-1:0] addr;
    logic [63:0]        wdata;
  } bm_req_t;
endpackage
`default_nettype wire

// ===== rtl/bsa_bitmap_ram.sv =====
// Bitmap word memory with one registered read and one write port.
`default_nettype none
module bsa_bitmap_ram
  import bsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire bm_req_t     req_i,
  input  wire logic [BmAddrW-1:0] raddr_i,
  output logic [63:0]      rdata_o
);
  logic [63:0] mem_q [BmDepth];
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/bitmap_slab_allocator_top.sv =====
// Top level of the slab allocator: sequencer, class state and bitmap search.
// An allocate scans the class bitmap word by word, and a free searches the pages of
// the class in order up to the match.
// Throughput: one word in flight; the next is taken only once the result has been accepted.
// Reset: asynchronous, active low; after reset a pass over all 576 words (BmDepth) clears
// the bitmap memory before the first request is taken.
`default_nettype none
`include "bitmap_slab_allocator_top_macros.svh"
module bitmap_slab_allocator_top
  import bsa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);
  fsm_e state_q, state_d;
  in_word_t req_q;
  logic [CidxW-1:0] cls_q;
  logic [PgW-1:0] pages_q [NumClasses];
  logic [CntW-1:0] free_q [NumClasses];
  logic [19:0] frame_q [FrDepth];
  logic [19:0] frame_rd_q;
  logic [WordW-1:0] word_q;
  logic [PgW-1:0] pidx_q;
  logic [SlotW-1:0] slot_q;
  logic clr_q;
  logic [BmAddrW-1:0] clr_cnt_q;
  logic [63:0] rdata;
  bm_req_t bm_req;
  logic [BmAddrW-1:0] raddr;
  out_word_t out_q;
  logic outv_q;

  bsa_bitmap_ram u_ram (.clk_i, .req_i(bm_req), .raddr_i(raddr), .rdata_o(rdata));

  // Class selection from the requested size.
  logic too_big;
  logic [CidxW-1:0] pick;
  always_comb begin
    too_big = 1'b1;
    pick = '0;
    for (int c = UsableClasses - 1; c >= 0; c--) begin
      if ({20'd0, in_data_i.object_size} <= (32'(MinObjBytes) << c)) begin
        too_big = 1'b0;
        pick = CidxW'(c);
      end
    end
  end

  logic [3:0] shift;
  logic [3:0] ppshift;
  logic [12:0] per_page;
  logic [CntW-1:0] pp_cnt;
  logic [PgW-1:0] npages;
  logic [WordW-1:0] last_word;
  assign shift = 4'(MinShift) + 4'(cls_q);
  assign ppshift = 4'(PageShift) - shift;
  assign per_page = 13'(PageBytes >> shift);
  assign pp_cnt = CntW'(per_page);
  assign npages = pages_q[cls_q];
  logic [SlotW+1:0] total;
  assign total = (SlotW+2)'(npages) * (SlotW+2)'(per_page);
  assign last_word = WordW'((total - 1) >> 6);

  logic grow_fail;
  assign grow_fail = (free_q[cls_q] == '0) &&
                     ((npages >= PgW'(MaxPages)) || (req_q.spare_page == '0));

  logic [FrAddrW-1:0] frow;
  assign frow = FrAddrW'(cls_q) * FrAddrW'(MaxPages) + FrAddrW'(pidx_q[PidxW-1:0]);

  // One-word lowest clear bit search.
  logic [5:0] lz;
  logic found0;
  always_comb begin
    lz = '0;
    found0 = 1'b0;
    for (int b = 63; b >= 0; b--) begin
      if (!rdata[b]) begin
        lz = 6'(b);
        found0 = 1'b1;
      end
    end
  end
  logic [SlotW+1:0] cand;
  assign cand = {2'b00, word_q, lz};
  logic hit_ok;
  assign hit_ok = found0 && (cand < total);

  logic [31:0] diff, pbase;
  assign pbase = {frame_rd_q[31-PageShift:0], {PageShift{1'b0}}};
  assign diff = req_q.free_address - pbase;
  logic dmatch;
  assign dmatch = (diff < 32'(PageBytes)) && ((diff & ((32'd1 << shift) - 1)) == 0);

  logic [SlotW-1:0] fslot, aslot;
  assign fslot = SlotW'((32'(pidx_q) << ppshift) + (diff >> shift));
  assign aslot = SlotW'(cand);
  logic [PidxW-1:0] apage;
  logic [12:0] aoff;
  assign apage = PidxW'(aslot >> ppshift);
  assign aoff = 13'(slot_q) & (per_page - 13'd1);
  logic [FrAddrW-1:0] arow;
  assign arow = FrAddrW'(cls_q) * FrAddrW'(MaxPages) + FrAddrW'(apage);
  logic [FrAddrW-1:0] faddr;
  assign faddr = (state_q == SScanChk) ? arow : frow;

  assign in_ready_o = (state_q == SIdle) && !clr_q && !outv_q;
  assign out_valid_o = outv_q;
  assign out_data_o = out_q;
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (acc) state_d = too_big ? SDone : (in_data_i.action ? SFreeRd : SGrow);
      SGrow: state_d = grow_fail ? SDone : SScanRd;
      SScanRd: state_d = SScanChk;
      SScanChk: state_d = hit_ok ? SAllocAddr : ((word_q == last_word) ? SDone : SScanRd);
      SAllocAddr: state_d = SDone;
      SFreeRd: state_d = (pidx_q >= npages) ? SDone : SFreeChk;
      SFreeChk: state_d = dmatch ? SFreeBmRd : SFreeRd;
      SFreeBmRd: state_d = SFreeBmChk;
      SFreeBmChk: state_d = SDone;
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    bm_req = '0;
    raddr = BmAddrW'(cls_q) * BmAddrW'(BitmapWords) + BmAddrW'(word_q);
    if (state_q == SFreeBmRd || state_q == SFreeBmChk)
      raddr = BmAddrW'(cls_q) * BmAddrW'(BitmapWords) + BmAddrW'(slot_q >> 6);
    if (clr_q) begin
      bm_req.we = 1'b1;
      bm_req.addr = clr_cnt_q;
    end else if (state_q == SScanChk && hit_ok) begin
      bm_req.we = 1'b1;
      bm_req.addr = raddr;
      bm_req.wdata = rdata | (64'd1 << lz);
    end else if (state_q == SFreeBmChk && rdata[slot_q[5:0]]) begin
      bm_req.we = 1'b1;
      bm_req.addr = raddr;
      bm_req.wdata = rdata & ~(64'd1 << slot_q[5:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) req_q <= in_data_i;
    if (state_q == SGrow && free_q[cls_q] == '0 && npages < PgW'(MaxPages)
        && req_q.spare_page != '0)
      frame_q[FrAddrW'(cls_q) * FrAddrW'(MaxPages) + FrAddrW'(npages[PidxW-1:0])]
        <= req_q.spare_page;
    frame_rd_q <= frame_q[faddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      outv_q <= 1'b0;
      out_q <= '0;
      cls_q <= '0;
      word_q <= '0;
      pidx_q <= '0;
      slot_q <= '0;
      for (int c = 0; c < NumClasses; c++) begin
        pages_q[c] <= '0;
        free_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == BmAddrW'(BmDepth - 1)) clr_q <= 1'b0;
      end
      if (outv_q && out_ready_i) outv_q <= 1'b0;
      case (state_q)
        SIdle: if (acc) begin
          cls_q <= pick;
          word_q <= '0;
          pidx_q <= '0;
          out_q <= {32'd0, too_big ? StTooBig : StOk, 1'b0, too_big ? 4'd0 : 4'(pick)};
        end
        SGrow: if (free_q[cls_q] == '0) begin
          if (npages >= PgW'(MaxPages)) out_q.status <= StPageLimit;
          else if (req_q.spare_page == '0) out_q.status <= StNoSpare;
          else begin
            pages_q[cls_q] <= npages + 1'b1;
            free_q[cls_q] <= free_q[cls_q] + pp_cnt;
            out_q.page_taken <= 1'b1;
          end
        end
        SScanChk: begin
          if (hit_ok) begin
            free_q[cls_q] <= free_q[cls_q] - 1'b1;
            slot_q <= aslot;
          end
          word_q <= word_q + 1'b1;
        end
        SAllocAddr: out_q.object_address <= {frame_rd_q[31-PageShift:0], {PageShift{1'b0}}}
                                            + (32'(aoff) << shift);
        SFreeRd: if (pidx_q >= npages) out_q.status <= StUnknown;
        SFreeChk: begin
          slot_q <= fslot;
          pidx_q <= pidx_q + 1'b1;
        end
        SFreeBmChk: begin
          if (rdata[slot_q[5:0]]) free_q[cls_q] <= free_q[cls_q] + 1'b1;
          else out_q.status <= StAlreadyFree;
        end
        SDone: outv_q <= 1'b1;
        default: ;
      endcase
    end
  end

  `BSA_NEVER(a_no_accept_busy, clk_i, rst_ni, acc && state_q != SIdle, "accept while busy")
  `BSA_NEVER(a_no_clear_accept, clk_i, rst_ni, clr_q && in_ready_o, "ready during clear")
  `BSA_ASSERT(a_done_valid, clk_i, rst_ni, state_q == SDone |=> outv_q, "result lost")
  `BSA_NEVER(a_pages_limit, clk_i, rst_ni, npages > PgW'(MaxPages), "page count overflow")
endmodule
`default_nettype wire

// ===== tb/tb_bitmap_slab_allocator_top.sv =====
// Testbench for the slab allocator: random and directed requests checked against a predictor.
`default_nettype none
module tb_bitmap_slab_allocator_top
  import bsa_pkg::*;
;

  class alloc_tracker;
    bit         slot_used[NumClasses][SlotsMax];
    bit [19:0]  frame_of[NumClasses][MaxPages];
    int         pages[NumClasses];
    int         free_cnt[NumClasses];
    out_word_t  pending_replies[$];
    bit [31:0]  live_addr[$];
    int         live_cls[$];
    bit [31:0]  freed_addr[$];
    int         freed_cls[$];
    int         errors;

    function void note_request(in_word_t w);
      out_word_t r;
      int c, bytes, per_page, total, slot, k;
      bit [31:0] base, diff;
      bit found;
      r = '0;
      c = -1;
      for (int i = 0; i < NumClasses; i++) begin
        if (c < 0 && (MinObjBytes << i) <= PageBytes && w.object_size <= (MinObjBytes << i))
          c = i;
      end
      if (c < 0) begin
        r.status = StTooBig;
      end else begin
        r.size_class = 4'(c);
        bytes = MinObjBytes << c;
        per_page = PageBytes / bytes;
        if (w.action == 1'b0) begin
          r.status = StOk;
          if (free_cnt[c] == 0) begin
            if (pages[c] >= MaxPages) begin
              r.status = StPageLimit;
            end else if (w.spare_page == 0) begin
              r.status = StNoSpare;
            end else begin
              frame_of[c][pages[c]] = w.spare_page;
              pages[c]++;
              free_cnt[c] += per_page;
              r.page_taken = 1'b1;
            end
          end
          if (r.status == StOk) begin
            total = pages[c] * per_page;
            for (int i = 0; i < total; i++) begin
              if (!slot_used[c][i]) begin
                base = {frame_of[c][i / per_page], 12'h000};
                r.object_address = base + 32'((i % per_page) * bytes);
                slot_used[c][i] = 1'b1;
                free_cnt[c]--;
                live_addr.push_back(r.object_address);
                live_cls.push_back(c);
                break;
              end
            end
          end
        end else begin
          found = 1'b0;
          slot = 0;
          for (int p = 0; p < pages[c] && !found; p++) begin
            base = {frame_of[c][p], 12'h000};
            diff = w.free_address - base;
            if (diff < PageBytes && diff % bytes == 0) begin
              slot = p * per_page + int'(diff / bytes);
              found = 1'b1;
            end
          end
          if (!found) begin
            r.status = StUnknown;
          end else if (!slot_used[c][slot]) begin
            r.status = StAlreadyFree;
          end else begin
            r.status = StOk;
            slot_used[c][slot] = 1'b0;
            free_cnt[c]++;
            k = -1;
            foreach (live_addr[j]) begin
              if (k < 0 && live_addr[j] == w.free_address && live_cls[j] == c) k = j;
            end
            if (k >= 0) begin
              live_addr.delete(k);
              live_cls.delete(k);
            end
            freed_addr.push_back(w.free_address);
            freed_cls.push_back(c);
          end
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (got.object_address !== exp_r.object_address) begin
        $error("object_address: expected %h, actual %h", exp_r.object_address,
               got.object_address);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.page_taken !== exp_r.page_taken) begin
        $error("page_taken: expected %0d, actual %0d", exp_r.page_taken, got.page_taken);
        errors++;
      end
      if (got.size_class !== exp_r.size_class) begin
        $error("size_class: expected %0d, actual %0d", exp_r.size_class, got.size_class);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  alloc_tracker tracker = new();
  bit quiet = 1'b0;
  int results_seen = 0;
  int idle_cycles = 0;

  bitmap_slab_allocator_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(in_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(w);
  endtask

  task automatic send_req(bit act, int size, bit [31:0] addr, bit [19:0] spare);
    in_word_t w;
    w.action = act;
    w.object_size = 12'(size);
    w.free_address = addr;
    w.spare_page = spare;
    send_word(w);
  endtask

  task automatic send_random();
    in_word_t w;
    int k, c, sel;
    w.action = 1'($urandom_range(0, 1));
    w.free_address = $urandom();
    w.spare_page = ($urandom_range(0, 9) == 0) ? 20'd0 : 20'($urandom_range(1, 20'hFFFFF));
    sel = $urandom_range(0, 19);
    if (sel == 0) w.object_size = '0;
    else if (sel == 1) w.object_size = 12'($urandom_range(2049, 4095));
    else w.object_size = 12'(MinObjBytes << $urandom_range(0, 8) >> $urandom_range(0, 1));
    if (sel > 4 && sel < 10) w.object_size = 12'($urandom_range(1, 2048));
    if (w.action) begin
      sel = $urandom_range(0, 19);
      if (sel < 13 && tracker.live_addr.size() > 0) begin
        k = $urandom_range(0, tracker.live_addr.size() - 1);
        c = tracker.live_cls[k];
        w.free_address = tracker.live_addr[k];
        w.object_size = 12'((MinObjBytes << c)
                            - $urandom_range(0, (MinObjBytes << c) / 2 - 1));
        if (sel == 0) w.object_size = 12'($urandom_range(1, 2048));
      end else if (sel < 16 && tracker.freed_addr.size() > 0) begin
        k = $urandom_range(0, tracker.freed_addr.size() - 1);
        w.free_address = tracker.freed_addr[k];
        w.object_size = 12'(MinObjBytes << tracker.freed_cls[k]);
      end else if (sel < 18 && tracker.live_addr.size() > 0) begin
        k = $urandom_range(0, tracker.live_addr.size() - 1);
        w.free_address = tracker.live_addr[k] + $urandom_range(1, 7);
      end
    end
    send_word(w);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_req(0, 0, 32'hFFFF_FFFF, 20'h00001);
    send_req(0, 1, 0, 20'h00002);
    send_req(0, 8, 0, 20'h00003);
    send_req(0, 9, 0, 20'hFFFFF);
    send_req(0, 2048, 0, 20'hFFFFF);
    send_req(0, 2049, 0, 20'h12345);
    send_req(0, 4095, 0, 20'h12345);
    send_req(0, 512, 0, 20'h00000);
    send_req(1, 2048, 32'hFFFF_F000, 0);
    send_req(1, 2048, 32'hFFFF_F800, 0);
    send_req(1, 2048, 32'hFFFF_F800, 0);
    send_req(1, 2048, 32'h0000_1234, 0);
    send_req(1, 16, 32'h0000_1000, 0);
    send_req(1, 8, 32'h0000_1000, 0);
    send_req(1, 4095, 32'h0000_1000, 0);
    for (int i = 0; i < 5; i++) send_req(0, 1024, 0, 20'h00777);
    send_req(1, 1000, 32'h0077_7400, 0);
    send_req(0, 1024, 0, 20'h00000);
    for (int i = 0; i < 450; i++) begin
      if (i == 400) quiet = 1'b1;
      send_random();
    end
    in_valid_i <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_reply(out_data_o);
        results_seen++;
        if (results_seen == 60) begin
          out_ready_i <= 1'b0;
          repeat (400) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b1;
        end
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_bitmap_ram.sv
rtl/bitmap_slab_allocator_top.sv
tb/tb_bitmap_slab_allocator_top.sv
